// ===== rtl/esr_pkg.sv =====
// Shared types, constants and CRC tables for the ESC status frame reassembler.
package esr_pkg;

  localparam int ID_W        = 29;
  localparam int LEN_W       = 4;
  localparam int DATA_W      = 64;
  localparam int CRC_W       = 16;
  localparam int TN_W        = 5;
  localparam int NODE_W      = 4;
  localparam int SIG_BYTES   = 8;
  localparam int PAY_BYTES   = 14;
  localparam int PAY_BITS    = PAY_BYTES * 8;
  localparam int STORE_BYTES = 12;   // payload bytes held across frames
  localparam int CFG_IDX_W   = 1;

  localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

  localparam logic [ID_W-1:0] ID_LOW_RESET  = 29'h18040A01;
  localparam logic [ID_W-1:0] ID_HIGH_RESET = 29'h18040A08;

  localparam logic [63:0]      TYPE_SIGNATURE = 64'hA9AF28AEA2FBB254;
  localparam logic [CRC_W-1:0] CRC_POLY       = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_SEED       = 16'hFFFF;

  // tail byte bits 7..5: start, end, toggle
  localparam logic [2:0] TAIL_FIRST  = 3'b100;
  localparam logic [2:0] TAIL_MIDDLE = 3'b001;
  localparam logic [2:0] TAIL_LAST   = 3'b010;

  localparam logic [CFG_IDX_W-1:0] CFG_ID_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_HIGH = 1'b1;

  typedef enum logic [2:0] {
    OUT_CONTINUE  = 3'd0,
    OUT_IGNORED   = 3'd1,
    OUT_RESTART   = 3'd2,
    OUT_CRC_ERROR = 3'd3,
    OUT_DECODED   = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  typedef logic [CRC_W-1:0] crc_t;
  typedef crc_t [PAY_BITS-1:0] crc_weight_t;

  function automatic crc_t crc_byte(crc_t c, logic [7:0] b);
    crc_t r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[CRC_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // CRC of seed, signature and an all-zero payload
  function automatic crc_t crc_base();
    crc_t c;
    c = CRC_SEED;
    for (int i = 0; i < SIG_BYTES; i++) begin
      c = crc_byte(c, TYPE_SIGNATURE[8*i +: 8]);
    end
    for (int i = 0; i < PAY_BYTES; i++) begin
      c = crc_byte(c, 8'h00);
    end
    return c;
  endfunction

  // Contribution of each payload bit to the final CRC (CRC is affine)
  function automatic crc_weight_t crc_weights();
    crc_weight_t w;
    crc_t        c;
    logic [7:0]  b;
    for (int p = 0; p < PAY_BYTES; p++) begin
      for (int j = 0; j < 8; j++) begin
        c = '0;
        for (int i = 0; i < SIG_BYTES + PAY_BYTES; i++) begin
          b = (i == SIG_BYTES + p) ? 8'(1 << j) : 8'h00;
          c = crc_byte(c, b);
        end
        w[p*8+j] = c;
      end
    end
    return w;
  endfunction

  localparam crc_t        CRC_BASE   = crc_base();
  localparam crc_weight_t CRC_WEIGHT = crc_weights();

endpackage

// ===== rtl/esr_if.sv =====
// Valid/ready channel interfaces for received frames and status reports.
interface esr_frame_if;
  logic        valid;
  logic        ready;
  logic [28:0] frame_id;
  logic [3:0]  length;
  logic [63:0] frame_data;

  modport source (output valid, frame_id, length, frame_data, input ready);
  modport sink   (input valid, frame_id, length, frame_data, output ready);
endinterface

interface esr_report_if;
  logic              valid;
  logic              ready;
  esr_pkg::outcome_t outcome;
  logic [3:0]        node_id;
  logic [31:0]       status_word;
  logic [15:0]       voltage_half;
  logic [15:0]       current_half;
  logic [15:0]       temperature_half;
  logic [17:0]       speed;
  logic [6:0]        throttle;
  logic [4:0]        slot_index;

  modport source (output valid, outcome, node_id, status_word, voltage_half, current_half,
                  temperature_half, speed, throttle, slot_index, input ready);
  modport sink   (input valid, outcome, node_id, status_word, voltage_half, current_half,
                  temperature_half, speed, throttle, slot_index, output ready);
endinterface

// ===== rtl/esc_status_frame_reassembler_unit.sv =====
// Top level: three-frame ESC status transfer reassembly with CRC check.
//
//  channel  | dir | handshake      | item
//  ---------+-----+----------------+-----------------------------------------
//  frames   | in  | valid/ready    | CAN frame: frame_id, length, frame_data
//  reports  | out | valid/ready    | outcome, node_id, raw status fields
//  cfg      | in  | cfg_we         | cfg_index selects id_low / id_high
//
// Each frame is registered on entry, classified in one pass and its report
// registered; one frame per cycle while the report register is not held.
// The entry register and the report register form a two-slot pipe, so a new
// frame is taken while a finished report waits; only a report held by a low
// reports.ready stalls the entry side. Transfer state updates when a frame
// moves into the report register. rst (synchronous) empties both slots,
// returns to the first-frame position and restores the default ID window.
module esc_status_frame_reassembler_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [esr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [esr_pkg::ID_W-1:0]          cfg_data,
  esr_frame_if.sink                         frames,
  esr_report_if.source                      reports
);
  import esr_pkg::*;

  // ID window registers
  logic [ID_W-1:0] id_low;
  logic [ID_W-1:0] id_high;

  // entry register
  logic              s1_valid;
  logic [ID_W-1:0]   s1_id;
  logic [LEN_W-1:0]  s1_len;
  logic [DATA_W-1:0] s1_data;

  // transfer state
  phase_t            phase;
  logic [ID_W-1:0]   first_frame_id;
  logic [TN_W-1:0]   transfer_number;
  logic [NODE_W-1:0] source_node;
  logic [CRC_W-1:0]  received_crc;
  logic [CRC_W-1:0]  crc_acc;          // CRC with the payload seen so far
  logic [7:0]        payload [STORE_BYTES];

  // report register
  logic              rep_valid;
  outcome_t          rep_outcome;
  logic [3:0]        rep_node;
  logic [31:0]       rep_status;
  logic [15:0]       rep_voltage;
  logic [15:0]       rep_current;
  logic [15:0]       rep_temp;
  logic [17:0]       rep_speed;
  logic [6:0]        rep_throttle;
  logic [4:0]        rep_slot;

  logic out_free;
  logic advance;

  assign out_free     = !rep_valid || reports.ready;
  assign advance      = s1_valid && out_free;
  assign frames.ready = !s1_valid || out_free;

  // ---- classification of the frame in the entry register ----
  logic [LEN_W-1:0] len_eff;
  logic [2:0]       tail_sel;
  logic [7:0]       tail;
  logic             len_zero;
  logic             in_range;
  logic             same_transfer;
  logic [CRC_W-1:0] contrib_first;
  logic [CRC_W-1:0] contrib_second;
  logic [CRC_W-1:0] contrib_last;
  logic [CRC_W-1:0] crc_final;
  logic [7:0]       last_b0;
  logic [7:0]       last_b1;

  phase_t           phase_next;
  logic             load_first;
  logic             load_second;
  outcome_t         outcome_next;
  logic [3:0]       node_next;
  logic             decoded;

  assign len_eff       = (s1_len > MAX_LEN) ? MAX_LEN : s1_len;
  assign len_zero      = (len_eff == '0);
  assign tail_sel      = 3'(len_eff - 4'd1);
  assign tail          = len_zero ? 8'h00 : s1_data[8*tail_sel +: 8];
  assign in_range      = (s1_id >= id_low) && (s1_id <= id_high);
  assign same_transfer = (s1_id == first_frame_id) && (tail[TN_W-1:0] == transfer_number);
  assign last_b0       = s1_data[7:0];
  assign last_b1       = s1_data[15:8];
  assign crc_final     = crc_acc ^ contrib_last;

  // CRC contributions: XOR of precomputed weights for set payload bits
  always_comb begin
    contrib_first  = '0;
    contrib_second = '0;
    contrib_last   = '0;
    for (int k = 0; k < 5; k++) begin
      for (int j = 0; j < 8; j++) begin
        contrib_first = contrib_first ^ (CRC_WEIGHT[k*8+j] & {CRC_W{s1_data[8*(k+2)+j]}});
      end
    end
    for (int k = 0; k < 7; k++) begin
      for (int j = 0; j < 8; j++) begin
        contrib_second = contrib_second ^ (CRC_WEIGHT[(k+5)*8+j] & {CRC_W{s1_data[8*k+j]}});
      end
    end
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 8; j++) begin
        contrib_last = contrib_last ^ (CRC_WEIGHT[(k+12)*8+j] & {CRC_W{s1_data[8*k+j]}});
      end
    end
  end

  always_comb begin
    phase_next   = PH_FIRST;
    load_first   = 1'b0;
    load_second  = 1'b0;
    decoded      = 1'b0;
    outcome_next = OUT_RESTART;
    node_next    = '0;
    case (phase)
      PH_SECOND: begin
        if (len_zero) begin
          // empty frame mid-transfer is skipped
          phase_next   = PH_SECOND;
          outcome_next = OUT_IGNORED;
          node_next    = source_node;
        end else if (in_range && tail[7:5] == TAIL_MIDDLE && same_transfer) begin
          phase_next   = PH_THIRD;
          load_second  = 1'b1;
          outcome_next = OUT_CONTINUE;
          node_next    = source_node;
        end
      end
      PH_THIRD: begin
        if (!len_zero && in_range && tail[7:5] == TAIL_LAST && same_transfer) begin
          node_next = source_node;
          if (crc_final == received_crc) begin
            outcome_next = OUT_DECODED;
            decoded      = 1'b1;
          end else begin
            outcome_next = OUT_CRC_ERROR;
          end
        end
      end
      default: begin
        // first position (an unused phase code also lands here)
        if (len_zero) begin
          outcome_next = OUT_IGNORED;
        end else if (in_range && tail[7:5] == TAIL_FIRST) begin
          phase_next   = PH_SECOND;
          load_first   = 1'b1;
          outcome_next = OUT_CONTINUE;
          node_next    = s1_id[NODE_W-1:0];
        end
      end
    endcase
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      id_low  <= ID_LOW_RESET;
      id_high <= ID_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ID_LOW:  id_low  <= cfg_data;
        CFG_ID_HIGH: id_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frames.valid && frames.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frames.valid && frames.ready) begin
      s1_id   <= frames.frame_id;
      s1_len  <= frames.length;
      s1_data <= frames.frame_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  // transfer payload; only read once the matching frame has loaded it
  always_ff @(posedge clk) begin
    if (advance && load_first) begin
      first_frame_id  <= s1_id;
      transfer_number <= tail[TN_W-1:0];
      source_node     <= s1_id[NODE_W-1:0];
      received_crc    <= {last_b1, last_b0};
      crc_acc         <= CRC_BASE ^ contrib_first;
      for (int k = 0; k < 5; k++) begin
        payload[k] <= s1_data[8*(k+2) +: 8];
      end
    end
    if (advance && load_second) begin
      crc_acc <= crc_acc ^ contrib_second;
      for (int k = 0; k < 7; k++) begin
        payload[k+5] <= s1_data[8*k +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_valid <= 1'b0;
    end else if (advance) begin
      rep_valid <= 1'b1;
    end else if (reports.ready) begin
      rep_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rep_outcome  <= outcome_next;
      rep_node     <= node_next;
      rep_status   <= decoded ? {payload[3], payload[2], payload[1], payload[0]} : '0;
      rep_voltage  <= decoded ? {payload[5], payload[4]} : '0;
      rep_current  <= decoded ? {payload[7], payload[6]} : '0;
      rep_temp     <= decoded ? {payload[9], payload[8]} : '0;
      rep_speed    <= decoded ? {last_b0[7:6], payload[11], payload[10]} : '0;
      rep_throttle <= decoded ? {last_b0[5:0], last_b1[7]} : '0;
      rep_slot     <= decoded ? last_b1[6:2] : '0;
    end
  end

  assign reports.valid            = rep_valid;
  assign reports.outcome          = rep_outcome;
  assign reports.node_id          = rep_node;
  assign reports.status_word      = rep_status;
  assign reports.voltage_half     = rep_voltage;
  assign reports.current_half     = rep_current;
  assign reports.temperature_half = rep_temp;
  assign reports.speed            = rep_speed;
  assign reports.throttle         = rep_throttle;
  assign reports.slot_index       = rep_slot;

  // ---- checks ----
  // entry side only stalls behind a held report
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !frames.ready |-> (s1_valid && rep_valid && !reports.ready))
    else $error("entry stalled without a held report");

  // a decoded or failed transfer always returns to the first-frame position
  a_end_phase: assert property (@(posedge clk) disable iff (rst)
    (rep_valid && (rep_outcome == OUT_DECODED || rep_outcome == OUT_CRC_ERROR))
      |-> (phase == PH_FIRST))
    else $error("transfer end did not return to first position");

  // a continuing report means a transfer is open
  a_continue_phase: assert property (@(posedge clk) disable iff (rst)
    (rep_valid && rep_outcome == OUT_CONTINUE) |-> (phase != PH_FIRST))
    else $error("continuing report with no open transfer");

  // status fields are zero unless decoded
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (rep_valid && rep_outcome != OUT_DECODED)
      |-> (rep_status == '0 && rep_speed == '0 && rep_slot == '0))
    else $error("status fields set on a non-decoded report");

endmodule

// ===== dv/esc_status_frame_reassembler_unit_test.sv =====
// Self-checking testbench for the ESC status frame reassembler: predictor, stimulus, checks.
module esc_status_frame_reassembler_unit_test;
  import esr_pkg::*;

  localparam int IDLE_LIMIT  = 2000;  // cycles without any handshake before giving up
  localparam int HOLD_CYCLES = 60;    // long receiver hold-off, well past the two-slot pipe
  localparam int SETTLE      = 4;     // extra margin after the last expected report is in

  localparam logic [ID_W-1:0] ID_MAX = '1;

  typedef logic [7:0] payload_t [PAY_BYTES];

  typedef struct packed {
    outcome_t    outcome;
    logic [3:0]  node_id;
    logic [31:0] status_word;
    logic [15:0] voltage_half;
    logic [15:0] current_half;
    logic [15:0] temperature_half;
    logic [17:0] speed;
    logic [6:0]  throttle;
    logic [4:0]  slot_index;
  } report_t;

  // ways a transfer can be spoiled by the stimulus
  typedef enum {
    FAULT_NONE, FAULT_CRC, FAULT_TAIL, FAULT_ID, FAULT_TN, FAULT_EMPTY_LAST, FAULT_CUT
  } fault_t;

  // receiver back-pressure patterns
  typedef enum {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} rx_mode_t;

  // ---------------------------------------------------------------------------
  // Transfer tracker: mirrors the block's reassembly state and queues the
  // report each accepted frame must produce.
  // ---------------------------------------------------------------------------
  class status_transfer_scoreboard;
    logic [ID_W-1:0]   win_low;
    logic [ID_W-1:0]   win_high;
    phase_t            phase;
    logic [ID_W-1:0]   first_id;
    logic [TN_W-1:0]   xfer_num;
    logic [NODE_W-1:0] src_node;
    crc_t              rx_crc;
    payload_t          pay;
    report_t           expected_reports [$];
    int                errors;
    int                outcome_count [5];

    function new();
      win_low  = ID_LOW_RESET;
      win_high = ID_HIGH_RESET;
      phase    = PH_FIRST;
      first_id = '0;
      xfer_num = '0;
      src_node = '0;
      rx_crc   = '0;
      foreach (pay[i]) pay[i] = 8'h00;
      errors = 0;
      foreach (outcome_count[i]) outcome_count[i] = 0;
    endfunction

    // CRC-16-CCITT, bit-serial, over type signature (low byte first) then payload
    static function crc_t status_crc(payload_t p);
      crc_t       c;
      logic [7:0] b;
      logic       fb;
      c = CRC_SEED;
      for (int i = 0; i < SIG_BYTES + PAY_BYTES; i++) begin
        if (i < SIG_BYTES) b = TYPE_SIGNATURE[8*i +: 8];
        else b = p[i - SIG_BYTES];
        for (int j = 7; j >= 0; j--) begin
          fb = c[CRC_W-1] ^ b[j];
          c  = {c[CRC_W-2:0], 1'b0};
          if (fb) c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    function void set_window(logic [ID_W-1:0] lo, logic [ID_W-1:0] hi);
      win_low  = lo;
      win_high = hi;
    endfunction

    function bit in_window(logic [ID_W-1:0] id);
      return id >= win_low && id <= win_high;
    endfunction

    function report_t reassemble(logic [ID_W-1:0] id, logic [LEN_W-1:0] len_in,
                                 logic [DATA_W-1:0] data);
      report_t          r;
      logic [LEN_W-1:0] len;
      logic [7:0]       tail;
      logic [2:0]       want;
      bit               ok;
      r    = '0;
      len  = (len_in > MAX_LEN) ? MAX_LEN : len_in;
      tail = (len != 0) ? data[8*(len-1) +: 8] : 8'h00;
      if (phase == PH_FIRST) begin
        // entering the first position wipes the partial transfer
        foreach (pay[i]) pay[i] = 8'h00;
        rx_crc   = '0;
        first_id = '0;
        if (len == 0) begin
          r.outcome = OUT_IGNORED;
        end else if (in_window(id) && tail[7:5] == TAIL_FIRST) begin
          src_node = id[NODE_W-1:0];
          first_id = id;
          xfer_num = tail[TN_W-1:0];
          rx_crc   = data[15:0];
          for (int i = 0; i < 5; i++) pay[i] = data[8*(i+2) +: 8];
          phase     = PH_SECOND;
          r.outcome = OUT_CONTINUE;
          r.node_id = src_node;
        end else begin
          r.outcome = OUT_RESTART;
        end
      end else if (len == 0 && phase == PH_SECOND) begin
        r.outcome = OUT_IGNORED;
        r.node_id = src_node;
      end else begin
        want = (phase == PH_SECOND) ? TAIL_MIDDLE : TAIL_LAST;
        ok = len != 0 && in_window(id) && tail[7:5] == want && id == first_id &&
             tail[TN_W-1:0] == xfer_num;
        if (!ok) begin
          phase     = PH_FIRST;
          first_id  = '0;
          r.outcome = OUT_RESTART;
        end else if (phase == PH_SECOND) begin
          for (int i = 0; i < 7; i++) pay[5+i] = data[8*i +: 8];
          phase     = PH_THIRD;
          r.outcome = OUT_CONTINUE;
          r.node_id = src_node;
        end else begin
          pay[12]   = data[7:0];
          pay[13]   = data[15:8];
          phase     = PH_FIRST;
          first_id  = '0;
          r.node_id = src_node;
          if (status_crc(pay) == rx_crc) begin
            r.outcome          = OUT_DECODED;
            r.status_word      = {pay[3], pay[2], pay[1], pay[0]};
            r.voltage_half     = {pay[5], pay[4]};
            r.current_half     = {pay[7], pay[6]};
            r.temperature_half = {pay[9], pay[8]};
            r.speed            = {pay[12][7:6], pay[11], pay[10]};
            r.throttle         = {pay[12][5:0], pay[13][7]};
            r.slot_index       = pay[13][6:2];
          end else begin
            r.outcome = OUT_CRC_ERROR;
          end
        end
      end
      return r;
    endfunction

    function void note_frame(logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                             logic [DATA_W-1:0] data);
      expected_reports.push_back(reassemble(id, len, data));
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
        errors++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want_r;
      if (expected_reports.size() == 0) begin
        $error("report with no frame pending: outcome %0d node %0d", got.outcome, got.node_id);
        errors++;
        return;
      end
      want_r = expected_reports.pop_front();
      outcome_count[want_r.outcome]++;
      compare_field("outcome", 32'(want_r.outcome), 32'(got.outcome));
      compare_field("node_id", 32'(want_r.node_id), 32'(got.node_id));
      compare_field("status_word", want_r.status_word, got.status_word);
      compare_field("voltage_half", 32'(want_r.voltage_half), 32'(got.voltage_half));
      compare_field("current_half", 32'(want_r.current_half), 32'(got.current_half));
      compare_field("temperature_half", 32'(want_r.temperature_half),
                    32'(got.temperature_half));
      compare_field("speed", 32'(want_r.speed), 32'(got.speed));
      compare_field("throttle", 32'(want_r.throttle), 32'(got.throttle));
      compare_field("slot_index", 32'(want_r.slot_index), 32'(got.slot_index));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, block
  // ---------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ID_W-1:0]      cfg_data = '0;

  esr_frame_if  frame_bus ();
  esr_report_if report_bus ();

  esc_status_frame_reassembler_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frames    (frame_bus),
    .reports   (report_bus)
  );

  status_transfer_scoreboard sb = new();

  int       burst_left = 0;   // frames left in the current sender burst
  int       frames_sent = 0;  // non-empty frames accepted
  int       windows_used = 1;
  int       holdoffs = 0;
  bit       hold_req = 1'b0;  // main flow asks the receiver for a long hold-off
  int       hold_cnt = 0;
  int       stall_tick = 0;
  rx_mode_t stall_mode = RX_OPEN;
  int       idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    frame_bus.valid      = 1'b0;
    frame_bus.frame_id   = '0;
    frame_bus.length     = '0;
    frame_bus.frame_data = '0;
    report_bus.ready     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 1'b0;
  end

  // Receiver: ready changes at the falling edge; a long hold-off on request,
  // otherwise a pattern from rx_mode_t, chosen anew at random as stall_tick advances.
  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 64 == 0) stall_mode = rx_mode_t'($urandom_range(0, 3));
    if (hold_cnt > 0) begin
      hold_cnt--;
      report_bus.ready = 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES - 1;
      holdoffs++;
      report_bus.ready = 1'b0;
    end else begin
      case (stall_mode)
        RX_OPEN:         report_bus.ready = 1'b1;
        RX_COIN:         report_bus.ready = 1'($urandom_range(0, 1));
        RX_EVERY_FOURTH: report_bus.ready = (stall_tick % 4 != 0);
        default:         report_bus.ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Report monitor: every accepted report is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && report_bus.valid && report_bus.ready)
      sb.check_report(report_t'{report_bus.outcome, report_bus.node_id,
                                report_bus.status_word, report_bus.voltage_half,
                                report_bus.current_half, report_bus.temperature_half,
                                report_bus.speed, report_bus.throttle,
                                report_bus.slot_index});
  end

  // Watchdog: too long with no handshake on either side means the block hung.
  always @(posedge clk) begin
    if ((frame_bus.valid && frame_bus.ready) || (report_bus.valid && report_bus.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks
  // ---------------------------------------------------------------------------

  // Offer one frame; bursts of random length with random gaps between them.
  // Returns at the rising edge where the frame was taken.
  task automatic send_frame(logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                            logic [DATA_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk) frame_bus.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    frame_bus.valid      = 1'b1;
    frame_bus.frame_id   = id;
    frame_bus.length     = len;
    frame_bus.frame_data = data;
    do @(posedge clk); while (!frame_bus.ready);
    sb.note_frame(id, len, data);
    if (len != 0) frames_sent++;
  endtask

  // Stop offering and wait until every expected report is in, plus pipe settling.
  task automatic wait_all_reports();
    @(negedge clk) frame_bus.valid = 1'b0;
    burst_left = 0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both window registers, written only while the block is idle.
  task automatic write_window(logic [ID_W-1:0] lo, logic [ID_W-1:0] hi);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_ID_LOW;
    cfg_data  = lo;
    @(negedge clk);
    cfg_index = CFG_ID_HIGH;
    cfg_data  = hi;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_window(lo, hi);
    windows_used++;
  endtask

  // One three-frame transfer. Frame 1: CRC + payload 0..4, frame 2: payload 5..11,
  // frame 3: payload 12..13; tail byte sits at the last valid byte. FAULT_CRC puts
  // a bad CRC in frame 1; other faults spoil the frame at bad_pos and drop the rest.
  task automatic send_transfer(logic [ID_W-1:0] id, logic [TN_W-1:0] tn, payload_t pay,
                               fault_t fault, int bad_pos, bit with_empties);
    crc_t              crc;
    logic [7:0]        d [8];
    logic [2:0]        flags;
    logic [ID_W-1:0]   fid;
    logic [TN_W-1:0]   fnum;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    int                eff;
    crc = status_transfer_scoreboard::status_crc(pay);
    if (fault == FAULT_CRC) crc = crc ^ CRC_W'($urandom_range(1, 16'hFFFF));
    for (int pos = 0; pos < 3; pos++) begin
      if (fault == FAULT_CUT && pos == bad_pos) return;
      // empty frames in the first two positions are skipped by the block
      if (with_empties && pos < 2 && $urandom_range(0, 3) == 0)
        send_frame(ID_W'($urandom), '0, {$urandom, $urandom});
      foreach (d[i]) d[i] = 8'($urandom);
      fid   = id;
      fnum  = tn;
      flags = (pos == 0) ? TAIL_FIRST : (pos == 1) ? TAIL_MIDDLE : TAIL_LAST;
      if (pos == 0) begin
        d[0] = crc[7:0];
        d[1] = crc[15:8];
        for (int i = 0; i < 5; i++) d[2+i] = pay[i];
      end else if (pos == 1) begin
        for (int i = 0; i < 7; i++) d[i] = pay[5+i];
      end else begin
        d[0] = pay[12];
        d[1] = pay[13];
      end
      // mostly nominal or oversized lengths; short ones let the tail clobber data
      if ($urandom_range(0, 9) == 0) len = LEN_W'($urandom_range(1, (pos == 2) ? 2 : 7));
      else if ($urandom_range(0, 1) == 0) len = (pos == 2) ? 4'd3 : MAX_LEN;
      else len = LEN_W'($urandom_range((pos == 2) ? 3 : 8, 15));
      if (pos == bad_pos) begin
        case (fault)
          FAULT_TAIL:       flags = flags ^ 3'($urandom_range(1, 7));
          FAULT_ID:         fid = id ^ ID_W'($urandom_range(1, 32'h1FFF_FFFF));
          FAULT_TN:         fnum = tn ^ TN_W'($urandom_range(1, 31));
          FAULT_EMPTY_LAST: len = '0;
          default: ;
        endcase
      end
      eff = int'((len > MAX_LEN) ? MAX_LEN : len);
      if (eff != 0) d[eff-1] = {flags, fnum};
      for (int i = 0; i < 8; i++) data[8*i +: 8] = d[i];
      send_frame(fid, len, data);
      if (pos == bad_pos && fault != FAULT_NONE && fault != FAULT_CRC) return;
    end
  endtask

  // Random traffic: mostly well-formed transfers in the current window, some
  // broken ones, some raw noise frames.
  task automatic run_random(int count);
    payload_t        pay;
    logic [ID_W-1:0] id;
    int              kind;
    int              stop_at;
    stop_at = frames_sent + count;
    while (frames_sent < stop_at) begin
      foreach (pay[i]) pay[i] = 8'($urandom);
      if (sb.win_low <= sb.win_high) id = ID_W'($urandom_range(sb.win_high, sb.win_low));
      else id = ID_W'($urandom);
      kind = $urandom_range(0, 99);
      if (kind < 70)
        send_transfer(id, TN_W'($urandom), pay, (kind < 7) ? FAULT_CRC : FAULT_NONE, 0, 1'b1);
      else if (kind < 85)
        send_transfer(id, TN_W'($urandom), pay, fault_t'($urandom_range(FAULT_TAIL, FAULT_CUT)),
                      $urandom_range(0, 2), 1'b1);
      else
        send_frame(ID_W'($urandom), LEN_W'($urandom), {$urandom, $urandom});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test flow
  // ---------------------------------------------------------------------------
  initial begin
    payload_t        pay;
    logic [ID_W-1:0] single;
    wait (!rst);

    // --- directed part, reset window ---
    // empty frame while idle: ignored, node reads zero
    send_frame('0, '0, '1);
    // highest in-window ID, top transfer number, all-ones payload
    foreach (pay[i]) pay[i] = 8'hFF;
    send_transfer(ID_HIGH_RESET, '1, pay, FAULT_NONE, 0, 1'b1);
    // lowest in-window ID, zero payload, bad CRC
    foreach (pay[i]) pay[i] = 8'h00;
    send_transfer(ID_LOW_RESET, '0, pay, FAULT_CRC, 0, 1'b0);
    // just outside the window on each side; length 15 acts as 8
    send_frame(ID_W'(ID_LOW_RESET - 1), MAX_LEN, {8'h80, 56'h0});
    send_frame(ID_W'(ID_HIGH_RESET + 1), 4'd15, {8'h80, 56'h0});
    // length one: the tail doubles as the CRC low byte, still starts a transfer
    send_frame(ID_LOW_RESET, 4'd1, 64'h80);
    // empty second position keeps the transfer alive
    send_frame(ID_LOW_RESET, '0, '0);
    send_frame(ID_LOW_RESET, MAX_LEN, {8'h20, 56'h0});
    // empty third position aborts it
    send_frame(ID_LOW_RESET, '0, '0);
    // tail flags wrong, identifier changed, transfer number changed
    send_transfer(ID_W'(ID_LOW_RESET + 2), 5'd7, pay, FAULT_TAIL, 1, 1'b0);
    send_transfer(ID_W'(ID_LOW_RESET + 3), 5'd9, pay, FAULT_ID, 2, 1'b0);
    send_transfer(ID_W'(ID_LOW_RESET + 4), 5'd21, pay, FAULT_TN, 1, 1'b0);

    // sender pauses until every report is back
    wait_all_reports();

    // --- random part over several ID windows ---
    run_random(300);
    wait_all_reports();
    run_random(100);

    wait_all_reports();
    write_window('0, ID_MAX);
    run_random(150);
    // receiver holds off for a long stretch while frames keep coming
    hold_req   = 1'b1;
    burst_left = 40;
    run_random(20);
    run_random(180);

    wait_all_reports();
    single = ID_W'($urandom);
    write_window(single, single);
    run_random(150);

    wait_all_reports();
    write_window(ID_MAX, ID_MAX);
    run_random(100);

    wait_all_reports();
    write_window('0, '0);
    run_random(100);

    // inverted window: nothing can start a transfer
    wait_all_reports();
    write_window(ID_MAX, '0);
    run_random(80);

    wait_all_reports();
    write_window(ID_LOW_RESET, ID_HIGH_RESET);
    hold_req   = 1'b1;
    burst_left = 40;
    run_random(120);

    wait_all_reports();

    $display("Ran %0d non-empty frames over %0d ID windows with %0d long receiver hold-offs.",
             frames_sent, windows_used, holdoffs);
    $display("Reports: %0d continuing, %0d ignored, %0d restarts, %0d CRC errors, %0d decoded.",
             sb.outcome_count[OUT_CONTINUE], sb.outcome_count[OUT_IGNORED],
             sb.outcome_count[OUT_RESTART], sb.outcome_count[OUT_CRC_ERROR],
             sb.outcome_count[OUT_DECODED]);
    if (sb.expected_reports.size() != 0)
      $error("%0d expected reports never arrived", sb.expected_reports.size());
    if (sb.errors == 0 && sb.expected_reports.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/esr_pkg.sv
rtl/esr_if.sv
rtl/esc_status_frame_reassembler_unit.sv
dv/esc_status_frame_reassembler_unit_test.sv
